[rtl/c3e_pkg.sv]
package c3e_pkg;

   // Default for the widest image row the history store is sized for.
   localparam int C3E_MAX_WIDTH = 1024;

   // Byte address width of the register port: six 32-bit registers.
   localparam int C3E_ADDR_W = 5;

   // One restoring step per cell gives one quotient bit; eight bits cover 0..255.
   localparam int C3E_DIV_CELLS = 8;

   // What travels from one divider cell to the next, four channel lanes wide.
   typedef struct packed {
      logic            valid;
      logic            eoi;
      logic [3:0]      sat;
      logic [3:0]      zero;
      logic [3:0][15:0] rem;
      logic [3:0][7:0]  quo;
   } c3e_stage_type;

   typedef enum logic [2:0] {
      C3E_ST_IDLE,
      C3E_ST_TAPS,
      C3E_ST_FLUSH,
      C3E_ST_LAUNCH,
      C3E_ST_DIV
   } c3e_state_type;

endpackage

[rtl/conv3x3_bgra_edge_replicate_unit.sv]
// Channel | Role            | Beat contents
// req     | pixel in        | tdata: blue, green, red, alpha; tuser: mode (1 = drain)
// rsp     | filtered pixel  | tdata: blue, green, red, alpha; tlast: end of image
// csr     | register port   | six 32-bit registers at byte address 4*index
//
// A beat that yields no result leaves the input open for the next beat. A beat that yields
// a result closes the input until that result leaves the divider, through these steps:
// nine reads through the single read port of the history store, a step to finish the sums,
// the launch, which waits for rsp to be free, a register for the sums in front of the divider,
// and eight divider cells. The result appears on rsp at the edge where the input opens again.
// Reset is synchronous; the history store is not cleared, only written pixels are read.
// A new beat is taken while a finished result still waits on rsp; a stalled rsp
// holds the next result in front of the divider chain.
module conv3x3_bgra_edge_replicate_unit #(
   parameter int MAX_WIDTH = c3e_pkg::C3E_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // in_blue, in_green, in_red, in_alpha
   input  logic                           req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,  // out_blue, out_green, out_red, out_alpha
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [c3e_pkg::C3E_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import c3e_pkg::*;

   localparam int HIST = 2 * MAX_WIDTH + 3;
   localparam int AW   = $clog2(HIST);
   localparam int SW   = AW + 2;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int PW   = $clog2(MAX_WIDTH + 3);
   localparam logic signed [SW-1:0] HIST_S = SW'(HIST);

   localparam logic [2:0] REG_KTOP   = 3'd0;
   localparam logic [2:0] REG_KMID   = 3'd1;
   localparam logic [2:0] REG_KBOT   = 3'd2;
   localparam logic [2:0] REG_NORM   = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   // Configuration registers
   logic [23:0] ktop_ff, kmid_ff, kbot_ff;
   logic [15:0] norm_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic        cfg_wr;
   logic [2:0]  cfg_idx;
   logic        restart;

   // Stream position and bookkeeping
   logic [AW-1:0] wr_ptr_ff;
   logic [PW-1:0] pending_ff, drainable_ff, pend_after;
   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [15:0]   in_row_ff, out_row_ff;
   logic [WW-1:0] ew, ew_m1;
   logic [15:0]   eh, eh_m1;
   logic [15:0]   n_eff;

   logic accept, pix, emit_now;
   logic in_last_col, in_last_row, out_last_col, out_last_row;

   // Work registers of the item being filtered
   logic [AW-1:0] base_ff, base_now;
   logic          up_ok_ff, dn_ok_ff, lf_ok_ff, rt_ok_ff, eoi_ff;
   logic [1:0]    r_ff, c_ff;

   logic signed [SW-1:0] row_off, col_off, addr_s, addr_fix;
   logic [AW-1:0]        tap_addr;

   logic [31:0] hist_mem [HIST];
   logic [31:0] rd_data_ff;
   logic        tap_v_ff;
   logic [1:0]  tap_r_d_ff, tap_c_d_ff;

   logic [23:0]        krow;
   logic signed [7:0]  coef;
   logic signed [16:0] prod  [4];
   logic signed [19:0] acc_ff [4];
   logic signed [19:0] acc_in [4];
   logic [3:0][19:0]   sums;

   c3e_state_type state_ff, state_in;
   logic          tap_issue, launch, taps_done;

   logic        chain_valid, chain_eoi;
   logic [31:0] chain_pixel;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [31:0] rsp_data_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx    = csr_paddr[4:2];
   assign restart    = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         ktop_ff   <= 24'h010101;
         kmid_ff   <= 24'h010101;
         kbot_ff   <= 24'h010101;
         norm_ff   <= 16'd2304;
         width_ff  <= 11'd1024;
         height_ff <= 16'd768;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_KTOP:   ktop_ff   <= csr_pwdata[23:0];
            REG_KMID:   kmid_ff   <= csr_pwdata[23:0];
            REG_KBOT:   kbot_ff   <= csr_pwdata[23:0];
            REG_NORM:   norm_ff   <= csr_pwdata[15:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_KTOP:   csr_prdata = {8'd0, ktop_ff};
         REG_KMID:   csr_prdata = {8'd0, kmid_ff};
         REG_KBOT:   csr_prdata = {8'd0, kbot_ff};
         REG_NORM:   csr_prdata = {16'd0, norm_ff};
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- effective geometry ----------------
   always_comb begin
      if (width_ff == 11'd0) begin
         ew = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         ew = WW'(MAX_WIDTH);
      end else begin
         ew = WW'(width_ff);
      end
      ew_m1 = WW'(ew - 1'b1);
      eh    = (height_ff == 16'd0) ? 16'd1 : height_ff;
      eh_m1 = eh - 16'd1;
      n_eff = (norm_ff == 16'd0) ? 16'd1 : norm_ff;
   end

   // ---------------- accept and bookkeeping ----------------
   assign accept       = req_tvalid & req_tready;
   assign pix          = ~req_tuser;
   assign in_last_col  = WW'(in_col_ff) == ew_m1;
   assign in_last_row  = in_row_ff == eh_m1;
   assign out_last_col = WW'(out_col_ff) == ew_m1;
   assign out_last_row = out_row_ff == eh_m1;

   always_comb begin
      if (pix) begin
         emit_now = 32'(pending_ff) > 32'(ew);
      end else begin
         emit_now = (drainable_ff != '0) && (pending_ff != '0);
      end
      pend_after = PW'(32'(pending_ff) + 32'(pix) - 32'(emit_now));
      // Oldest pending pixel; the same for pixel and drain beats.
      if ((AW+1)'(wr_ptr_ff) >= (AW+1)'(pending_ff)) begin
         base_now = AW'(32'(wr_ptr_ff) - 32'(pending_ff));
      end else begin
         base_now = AW'(32'(wr_ptr_ff) + HIST - 32'(pending_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         wr_ptr_ff    <= '0;
         pending_ff   <= '0;
         drainable_ff <= '0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
      end else if (accept) begin
         pending_ff <= pend_after;
         if (pix && in_last_col && in_last_row) begin
            drainable_ff <= pend_after;
         end else if (emit_now && drainable_ff != '0) begin
            drainable_ff <= drainable_ff - 1'b1;
         end
         if (pix) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == HIST - 1) ? '0 : wr_ptr_ff + 1'b1;
            if (in_last_col) begin
               in_col_ff <= '0;
               in_row_ff <= in_last_row ? 16'd0 : in_row_ff + 16'd1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (emit_now) begin
            if (out_last_col) begin
               out_col_ff <= '0;
               out_row_ff <= out_last_row ? 16'd0 : out_row_ff + 16'd1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   // Edge replication reduces to which neighbors exist around the output pixel.
   always_ff @(posedge clock) begin
      if (accept && emit_now) begin
         base_ff  <= base_now;
         up_ok_ff <= out_row_ff != 16'd0;
         dn_ok_ff <= !out_last_row;
         lf_ok_ff <= out_col_ff != '0;
         rt_ok_ff <= !out_last_col;
         eoi_ff   <= out_last_row && out_last_col;
      end
   end

   // ---------------- tap sequencer ----------------
   assign taps_done = (r_ff == 2'd2) && (c_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset || accept) begin
         r_ff <= 2'd0;
         c_ff <= 2'd0;
      end else if (tap_issue && !taps_done) begin
         if (c_ff == 2'd2) begin
            c_ff <= 2'd0;
            r_ff <= r_ff + 2'd1;
         end else begin
            c_ff <= c_ff + 2'd1;
         end
      end
   end

   always_comb begin
      case (r_ff)
         2'd0:    row_off = up_ok_ff ? -$signed(SW'(ew)) : '0;
         2'd2:    row_off = dn_ok_ff ? $signed(SW'(ew)) : '0;
         default: row_off = '0;
      endcase
      case (c_ff)
         2'd0:    col_off = lf_ok_ff ? -SW'(1) : '0;
         2'd2:    col_off = rt_ok_ff ? SW'(1) : '0;
         default: col_off = '0;
      endcase
      addr_s = $signed(SW'(base_ff)) + row_off + col_off;
      if (addr_s < 0) begin
         addr_fix = addr_s + HIST_S;
      end else if (addr_s >= HIST_S) begin
         addr_fix = addr_s - HIST_S;
      end else begin
         addr_fix = addr_s;
      end
      tap_addr = addr_fix[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept && pix) begin
         hist_mem[wr_ptr_ff] <= req_tdata;
      end
      if (tap_issue) begin
         rd_data_ff <= hist_mem[tap_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_v_ff <= 1'b0;
      end else begin
         tap_v_ff <= tap_issue;
      end
      tap_r_d_ff <= r_ff;
      tap_c_d_ff <= c_ff;
   end

   // ---------------- multiply-accumulate ----------------
   always_comb begin
      case (tap_r_d_ff)
         2'd0:    krow = ktop_ff;
         2'd1:    krow = kmid_ff;
         default: krow = kbot_ff;
      endcase
      case (tap_c_d_ff)
         2'd0:    coef = $signed(krow[7:0]);
         2'd1:    coef = $signed(krow[15:8]);
         default: coef = $signed(krow[23:16]);
      endcase
      for (int ch = 0; ch < 4; ch++) begin
         prod[ch] = $signed({1'b0, rd_data_ff[8*ch +: 8]}) * coef;
         if (accept) begin
            acc_in[ch] = '0;
         end else if (tap_v_ff) begin
            acc_in[ch] = acc_ff[ch] + 20'(prod[ch]);
         end else begin
            acc_in[ch] = acc_ff[ch];
         end
         sums[ch] = acc_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 4; ch++) begin
         acc_ff[ch] <= acc_in[ch];
      end
   end

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C3E_ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C3E_ST_IDLE:   if (accept && emit_now) state_in = C3E_ST_TAPS;
         C3E_ST_TAPS:   if (taps_done) state_in = C3E_ST_FLUSH;
         C3E_ST_FLUSH:  state_in = C3E_ST_LAUNCH;
         C3E_ST_LAUNCH: if (launch) state_in = C3E_ST_DIV;
         C3E_ST_DIV:    if (chain_valid) state_in = C3E_ST_IDLE;
         default:       state_in = C3E_ST_IDLE;
      endcase
   end

   // The divider is launched only when the output register is free by the time
   // its result arrives; nothing else can fill it meanwhile.
   always_comb begin
      req_tready = state_ff == C3E_ST_IDLE;
      tap_issue  = state_ff == C3E_ST_TAPS;
      launch     = (state_ff == C3E_ST_LAUNCH) && (!rsp_valid_ff || rsp_tready);
   end

   c3e_div_chain u_div_chain (
      .clock        (clock),
      .reset        (reset),
      .launch       (launch),
      .launch_eoi   (eoi_ff),
      .sums         (sums),
      .divisor      (n_eff),
      .result_valid (chain_valid),
      .result_pixel (chain_pixel),
      .result_eoi   (chain_eoi)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (chain_valid) begin
         rsp_data_ff <= chain_pixel;
         rsp_last_ff <= chain_eoi;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/c3e_div_cell.sv]
module c3e_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            divisor,
   input  c3e_pkg::c3e_stage_type prev_stage,
   output c3e_pkg::c3e_stage_type next_stage
);
   import c3e_pkg::*;

   c3e_stage_type   stage_ff;
   c3e_stage_type   stage_in;
   logic [3:0][16:0] dbl;
   logic [3:0]       ge;

   // One restoring division step per lane: the remainder stays below the divisor.
   always_comb begin
      stage_in = prev_stage;
      for (int l = 0; l < 4; l++) begin
         dbl[l] = {prev_stage.rem[l], 1'b0};
         ge[l]  = dbl[l] >= {1'b0, divisor};
         stage_in.rem[l] = ge[l] ? 16'(dbl[l] - {1'b0, divisor}) : dbl[l][15:0];
         stage_in.quo[l] = {prev_stage.quo[l][6:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

[rtl/c3e_div_chain.sv]
module c3e_div_chain (
   input  logic             clock,
   input  logic             reset,
   input  logic             launch,
   input  logic             launch_eoi,
   input  logic [3:0][19:0] sums,
   input  logic [15:0]      divisor,
   output logic             result_valid,
   output logic [31:0]      result_pixel,
   output logic             result_eoi
);
   import c3e_pkg::*;

   c3e_stage_type front_ff;
   c3e_stage_type front_in;
   c3e_stage_type links [C3E_DIV_CELLS+1];
   c3e_stage_type last;

   // A sum at or above the divisor saturates; a sum at or below zero gives zero.
   // Otherwise the sum itself is the starting remainder of sum*256/divisor.
   always_comb begin
      front_in       = '0;
      front_in.valid = launch;
      front_in.eoi   = launch_eoi;
      for (int l = 0; l < 4; l++) begin
         front_in.sat[l]  = $signed(sums[l]) >= $signed({4'b0, divisor});
         front_in.zero[l] = $signed(sums[l]) <= $signed(20'd0);
         front_in.rem[l]  = sums[l][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
      end else begin
         front_ff <= front_in;
      end
   end

   assign links[0] = front_ff;

   for (genvar g = 0; g < C3E_DIV_CELLS; g++) begin : g_cell
      c3e_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .divisor    (divisor),
         .prev_stage (links[g]),
         .next_stage (links[g+1])
      );
   end

   assign last         = links[C3E_DIV_CELLS];
   assign result_valid = last.valid;
   assign result_eoi   = last.eoi;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (last.sat[l]) begin
            result_pixel[8*l +: 8] = 8'hFF;
         end else if (last.zero[l]) begin
            result_pixel[8*l +: 8] = 8'h00;
         end else begin
            result_pixel[8*l +: 8] = last.quo[l];
         end
      end
   end

endmodule
